// ===== rtl/cpu_slot_registry_macros.svh =====
// ----------------------------------------------------------------------------
// cpu slot registry assertion macros
// concurrent assertion helpers, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef CPU_SLOT_REGISTRY_MACROS_SVH
`define CPU_SLOT_REGISTRY_MACROS_SVH

`ifndef SYNTHESIS
// same cycle implication
`define CSR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpu slot registry assertion failed");
// next cycle implication
`define CSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpu slot registry assertion failed");
`else
`define CSR_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define CSR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/csr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_pkg
// shared types and constants of the cpu slot registry
// ----------------------------------------------------------------------------
package csr_pkg;

    localparam int CPU_SLOTS_DEF = 16;
    localparam int ID_W          = 32;
    localparam int GEN_W         = 32;
    localparam int SLOT_FIELD_W  = 8;

    localparam logic [SLOT_FIELD_W-1:0] NO_SLOT = '1;
    localparam logic [ID_W-1:0]         BAD_ID  = '1;
    localparam logic [GEN_W-1:0]        GEN_MAX = '1;
    localparam logic [GEN_W-1:0]        GEN_FIRST = GEN_W'(1);

    typedef enum logic [2:0] {
        OP_INIT     = 3'd0,
        OP_ONLINE   = 3'd1,
        OP_OFFLINE  = 3'd2,
        OP_LOOKUP   = 3'd3,
        OP_HANDLE   = 3'd4,
        OP_RESOLVE  = 3'd5,
        OP_SNAPSHOT = 3'd6,
        OP_UNUSED   = 3'd7
    } t_opcode;

    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_NOT_INIT       = 4'd1,
        ST_POISONED       = 4'd2,
        ST_ALREADY_INIT   = 4'd3,
        ST_BAD_CPU        = 4'd4,
        ST_BAD_ID         = 4'd5,
        ST_ALREADY_ONLINE = 4'd6,
        ST_DUP_ID         = 4'd7,
        ST_GEN_EXHAUSTED  = 4'd8,
        ST_OFFLINE        = 4'd9,
        ST_BOOT_CPU       = 4'd10,
        ST_STALE          = 4'd11
    } t_status;

    // contents of one slot
    typedef struct packed {
        logic [ID_W-1:0]  apic;
        logic [GEN_W-1:0] gen;
        logic             online;
        logic             boot;
    } t_slot_rd;

    // update request for the slot table
    typedef struct packed {
        logic             clear_all;
        logic             set_online;
        logic             set_offline;
        logic             boot;
        logic [ID_W-1:0]  apic;
        logic [GEN_W-1:0] gen;
    } t_slot_wr;

endpackage

// ===== rtl/csr_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_slot_table
// per slot registers with indexed read, parallel id match and slot update
// ----------------------------------------------------------------------------
module csr_slot_table #(
    parameter int CPU_SLOTS = csr_pkg::CPU_SLOTS_DEF,
    parameter int SLOT_W    = $clog2(CPU_SLOTS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [SLOT_W-1:0]        i_rd_idx,
    output csr_pkg::t_slot_rd        o_rd,
    input  logic [csr_pkg::ID_W-1:0] i_lookup_id,
    output logic                     o_hit,
    output logic [SLOT_W-1:0]        o_hit_idx,
    input  csr_pkg::t_slot_wr        i_wr,
    input  logic [SLOT_W-1:0]        i_wr_idx
);

    logic [csr_pkg::ID_W-1:0]  r_apic   [CPU_SLOTS];
    logic [csr_pkg::GEN_W-1:0] r_gen    [CPU_SLOTS];
    logic [CPU_SLOTS-1:0]      r_online;
    logic [CPU_SLOTS-1:0]      r_boot;
    logic [CPU_SLOTS-1:0]      match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CPU_SLOTS; i++) begin
                r_apic[i] <= csr_pkg::BAD_ID;
                r_gen[i]  <= '0;
            end
            r_online <= '0;
            r_boot   <= '0;
        end else begin
            for (int i = 0; i < CPU_SLOTS; i++) begin
                if (i_wr.clear_all) begin
                    r_apic[i]   <= csr_pkg::BAD_ID;
                    r_gen[i]    <= '0;
                    r_online[i] <= 1'b0;
                    r_boot[i]   <= 1'b0;
                end
                if (SLOT_W'(i) == i_wr_idx) begin
                    if (i_wr.set_online) begin
                        r_apic[i]   <= i_wr.apic;
                        r_gen[i]    <= i_wr.gen;
                        r_online[i] <= 1'b1;
                        if (i_wr.boot) begin
                            r_boot[i] <= 1'b1;
                        end
                    end
                    if (i_wr.set_offline) begin
                        r_apic[i]   <= csr_pkg::BAD_ID;
                        r_online[i] <= 1'b0;
                    end
                end
            end
        end
    end

    // parallel id compare, lowest slot wins
    always_comb begin
        o_hit     = 1'b0;
        o_hit_idx = '0;
        for (int i = 0; i < CPU_SLOTS; i++) begin
            match[i] = r_online[i] && (r_apic[i] == i_lookup_id);
        end
        for (int i = CPU_SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                o_hit     = 1'b1;
                o_hit_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        o_rd.apic   = r_apic[i_rd_idx];
        o_rd.gen    = r_gen[i_rd_idx];
        o_rd.online = r_online[i_rd_idx];
        o_rd.boot   = r_boot[i_rd_idx];
    end

endmodule

// ===== rtl/csr_exec.sv =====
`timescale 1ns / 1ps
`include "cpu_slot_registry_macros.svh"
// ----------------------------------------------------------------------------
// csr_exec
// operation decode, checks, global registry state and result register
// ----------------------------------------------------------------------------
module csr_exec #(
    parameter int CPU_SLOTS = csr_pkg::CPU_SLOTS_DEF,
    parameter int SLOT_W    = $clog2(CPU_SLOTS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [2:0]                       i_opcode,
    input  logic [csr_pkg::SLOT_FIELD_W-1:0] i_slot_index,
    input  logic [csr_pkg::ID_W-1:0]         i_apic_value,
    input  logic [csr_pkg::GEN_W-1:0]        i_handle_generation,
    output logic [SLOT_W-1:0]                o_rd_idx,
    input  csr_pkg::t_slot_rd                i_rd,
    input  logic                             i_hit,
    input  logic [SLOT_W-1:0]                i_hit_idx,
    output csr_pkg::t_slot_wr                o_wr,
    output logic [SLOT_W-1:0]                o_wr_idx,
    output logic                             o_strobe,
    output logic [3:0]                       o_status,
    output logic [csr_pkg::SLOT_FIELD_W-1:0] o_found_slot,
    output logic [csr_pkg::ID_W-1:0]         o_slot_apic,
    output logic [csr_pkg::GEN_W-1:0]        o_slot_generation,
    output logic                             o_slot_online,
    output logic                             o_slot_is_boot
);

    logic                             r_init, n_init;
    logic                             r_poisoned, n_poisoned;
    logic [csr_pkg::GEN_W-1:0]        r_next_tag, n_next_tag;
    logic                             r_res_valid;
    csr_pkg::t_status                 r_status, n_status;
    logic [csr_pkg::SLOT_FIELD_W-1:0] r_found, n_found;
    logic [csr_pkg::ID_W-1:0]         r_apic, n_apic;
    logic [csr_pkg::GEN_W-1:0]        r_gen, n_gen;
    logic                             r_on, n_on;
    logic                             r_boot, n_boot;

    logic             in_range;
    logic [SLOT_W-1:0] k;
    csr_pkg::t_status gate_st;

    assign in_range = i_slot_index < csr_pkg::SLOT_FIELD_W'(CPU_SLOTS);
    assign k        = in_range ? i_slot_index[SLOT_W-1:0] : '0;
    assign o_rd_idx = k;
    assign o_wr_idx = k;
    assign gate_st  = r_poisoned ? csr_pkg::ST_POISONED :
                      (!r_init ? csr_pkg::ST_NOT_INIT : csr_pkg::ST_OK);

    always_comb begin
        n_status   = csr_pkg::ST_OK;
        n_found    = csr_pkg::NO_SLOT;
        n_apic     = csr_pkg::BAD_ID;
        n_gen      = '0;
        n_on       = 1'b0;
        n_boot     = 1'b0;
        n_init     = r_init;
        n_poisoned = r_poisoned;
        n_next_tag = r_next_tag;
        o_wr       = '0;
        o_wr.apic  = i_apic_value;
        o_wr.gen   = r_next_tag;
        if (i_valid) begin
            if (csr_pkg::t_opcode'(i_opcode) == csr_pkg::OP_INIT) begin
                if (r_init) begin
                    n_status = csr_pkg::ST_ALREADY_INIT;
                end else if (!in_range) begin
                    n_status = csr_pkg::ST_BAD_CPU;
                end else if (i_apic_value == csr_pkg::BAD_ID) begin
                    n_status = csr_pkg::ST_BAD_ID;
                end else begin
                    o_wr.clear_all  = 1'b1;
                    o_wr.set_online = 1'b1;
                    o_wr.boot       = 1'b1;
                    o_wr.gen        = csr_pkg::GEN_FIRST;
                    n_next_tag      = csr_pkg::GEN_FIRST + csr_pkg::GEN_W'(1);
                    n_init          = 1'b1;
                end
            end else if (gate_st != csr_pkg::ST_OK) begin
                if (i_opcode != csr_pkg::OP_UNUSED) begin
                    n_status = gate_st;
                end
            end else begin
                unique case (csr_pkg::t_opcode'(i_opcode))
                    csr_pkg::OP_ONLINE: begin
                        if (!in_range) begin
                            n_status = csr_pkg::ST_BAD_CPU;
                        end else if (i_apic_value == csr_pkg::BAD_ID) begin
                            n_status = csr_pkg::ST_BAD_ID;
                        end else if (i_rd.online) begin
                            n_status = csr_pkg::ST_ALREADY_ONLINE;
                        end else if (i_hit) begin
                            n_status = csr_pkg::ST_DUP_ID;
                        end else if (r_next_tag == csr_pkg::GEN_MAX) begin
                            n_poisoned = 1'b1;
                            n_status   = csr_pkg::ST_GEN_EXHAUSTED;
                        end else begin
                            o_wr.set_online = 1'b1;
                            n_next_tag      = r_next_tag + csr_pkg::GEN_W'(1);
                        end
                    end
                    csr_pkg::OP_OFFLINE: begin
                        if (!in_range) begin
                            n_status = csr_pkg::ST_BAD_CPU;
                        end else if (!i_rd.online) begin
                            n_status = csr_pkg::ST_OFFLINE;
                        end else if (i_rd.boot) begin
                            n_status = csr_pkg::ST_BOOT_CPU;
                        end else begin
                            o_wr.set_offline = 1'b1;
                        end
                    end
                    csr_pkg::OP_LOOKUP: begin
                        if (i_apic_value == csr_pkg::BAD_ID) begin
                            n_status = csr_pkg::ST_BAD_ID;
                        end else if (i_hit) begin
                            n_found = csr_pkg::SLOT_FIELD_W'(i_hit_idx);
                        end else begin
                            n_status = csr_pkg::ST_OFFLINE;
                        end
                    end
                    csr_pkg::OP_HANDLE: begin
                        if (!in_range) begin
                            n_status = csr_pkg::ST_BAD_CPU;
                        end else if (!i_rd.online) begin
                            n_status = csr_pkg::ST_OFFLINE;
                        end else begin
                            n_found = csr_pkg::SLOT_FIELD_W'(k);
                            n_gen   = i_rd.gen;
                        end
                    end
                    csr_pkg::OP_RESOLVE: begin
                        if (!in_range) begin
                            n_status = csr_pkg::ST_BAD_CPU;
                        end else if (!i_rd.online || i_handle_generation == '0 ||
                                     i_rd.gen != i_handle_generation) begin
                            n_status = csr_pkg::ST_STALE;
                        end else begin
                            n_found = csr_pkg::SLOT_FIELD_W'(k);
                        end
                    end
                    csr_pkg::OP_SNAPSHOT: begin
                        if (!in_range) begin
                            n_status = csr_pkg::ST_BAD_CPU;
                        end else begin
                            n_apic = i_rd.apic;
                            n_gen  = i_rd.gen;
                            n_on   = i_rd.online;
                            n_boot = i_rd.boot;
                        end
                    end
                    default: begin
                        n_status = csr_pkg::ST_OK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b0;
            r_poisoned  <= 1'b0;
            r_next_tag  <= csr_pkg::GEN_FIRST;
            r_res_valid <= 1'b0;
        end else begin
            r_init      <= n_init;
            r_poisoned  <= n_poisoned;
            r_next_tag  <= n_next_tag;
            r_res_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_apic   <= n_apic;
        r_gen    <= n_gen;
        r_on     <= n_on;
        r_boot   <= n_boot;
    end

    assign o_strobe          = r_res_valid;
    assign o_status          = r_status;
    assign o_found_slot      = r_found;
    assign o_slot_apic       = r_apic;
    assign o_slot_generation = r_gen;
    assign o_slot_online     = r_on;
    assign o_slot_is_boot    = r_boot;

    `CSR_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_valid, r_res_valid)
    `CSR_ASSERT_NEXT(a_poison_sticks, i_clk, i_rst_n, r_poisoned, r_poisoned)
    `CSR_ASSERT_NEXT(a_init_sticks, i_clk, i_rst_n, r_init, r_init)
    `CSR_ASSERT_NEXT(a_poison_reported, i_clk, i_rst_n,
        i_valid && r_poisoned && i_opcode != csr_pkg::OP_INIT && i_opcode != csr_pkg::OP_UNUSED,
        r_status == csr_pkg::ST_POISONED)
    `CSR_ASSERT_NOW(a_exhaust_poisons, i_clk, i_rst_n,
        r_res_valid && r_status == csr_pkg::ST_GEN_EXHAUSTED, r_poisoned)

endmodule

// ===== rtl/cpu_slot_registry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_slot_registry
// registry of cpu slots with ids, generation handles and online state
// ----------------------------------------------------------------------------
// usage
//   command channel: a transaction is taken at a rising edge with start high
//   and busy low; busy stays low, so a command can be issued every cycle.
//   fields: i_opcode, i_slot_index, i_apic_value, i_handle_generation.
//   result channel: o_strobe is high for exactly one cycle per command, with
//   o_status, o_found_slot, o_slot_apic, o_slot_generation, o_slot_online
//   and o_slot_is_boot valid in that cycle.
//   path: a command passes from the input register through the slot table
//   compare and update into the result register, which raises the result
//   strobe; throughput one command per cycle, set by that single pass.
//   results come out in command order; each command sees the slot state
//   left by the one before it.
//   reset (synchronous, active low): all slots offline, registry not
//   initialized and not poisoned, generation counter at one.
//   the receiver cannot stall: a result is present for one cycle only.
// ----------------------------------------------------------------------------
module cpu_slot_registry #(
    parameter int CPU_SLOTS = csr_pkg::CPU_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_opcode,
    input  logic [csr_pkg::SLOT_FIELD_W-1:0] i_slot_index,
    input  logic [csr_pkg::ID_W-1:0]         i_apic_value,
    input  logic [csr_pkg::GEN_W-1:0]        i_handle_generation,
    output logic                             o_strobe,
    output logic [3:0]                       o_status,
    output logic [csr_pkg::SLOT_FIELD_W-1:0] o_found_slot,
    output logic [csr_pkg::ID_W-1:0]         o_slot_apic,
    output logic [csr_pkg::GEN_W-1:0]        o_slot_generation,
    output logic                             o_slot_online,
    output logic                             o_slot_is_boot
);

    localparam int SLOT_W = $clog2(CPU_SLOTS);

    logic                             r_in_valid;
    logic [2:0]                       r_opcode;
    logic [csr_pkg::SLOT_FIELD_W-1:0] r_slot_index;
    logic [csr_pkg::ID_W-1:0]         r_apic_value;
    logic [csr_pkg::GEN_W-1:0]        r_handle_generation;

    logic [SLOT_W-1:0] rd_idx;
    logic [SLOT_W-1:0] wr_idx;
    logic [SLOT_W-1:0] hit_idx;
    logic              hit;
    csr_pkg::t_slot_rd rd;
    csr_pkg::t_slot_wr wr;

    assign busy = 1'b0;

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_opcode            <= i_opcode;
            r_slot_index        <= i_slot_index;
            r_apic_value        <= i_apic_value;
            r_handle_generation <= i_handle_generation;
        end
    end

    csr_slot_table #(
        .CPU_SLOTS (CPU_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_idx    (rd_idx),
        .o_rd        (rd),
        .i_lookup_id (r_apic_value),
        .o_hit       (hit),
        .o_hit_idx   (hit_idx),
        .i_wr        (wr),
        .i_wr_idx    (wr_idx)
    );

    csr_exec #(
        .CPU_SLOTS (CPU_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_exec (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (r_in_valid),
        .i_opcode            (r_opcode),
        .i_slot_index        (r_slot_index),
        .i_apic_value        (r_apic_value),
        .i_handle_generation (r_handle_generation),
        .o_rd_idx            (rd_idx),
        .i_rd                (rd),
        .i_hit               (hit),
        .i_hit_idx           (hit_idx),
        .o_wr                (wr),
        .o_wr_idx            (wr_idx),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_found_slot        (o_found_slot),
        .o_slot_apic         (o_slot_apic),
        .o_slot_generation   (o_slot_generation),
        .o_slot_online       (o_slot_online),
        .o_slot_is_boot      (o_slot_is_boot)
    );

endmodule

// ===== tb/sv/cpu_slot_registry_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_slot_registry_checker
// watches the command and result channels of the cpu slot registry, keeps
// its own copy of the slot table, predicts the reply to every command taken
// and compares each reply strobe field by field against the oldest prediction
// ----------------------------------------------------------------------------
module cpu_slot_registry_checker
    import csr_pkg::*;
#(
    parameter int CPU_SLOTS = CPU_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [2:0]              i_opcode,
    input  logic [SLOT_FIELD_W-1:0] i_slot_index,
    input  logic [ID_W-1:0]         i_apic_value,
    input  logic [GEN_W-1:0]        i_handle_generation,
    input  logic                    i_strobe,
    input  logic [3:0]              i_status,
    input  logic [SLOT_FIELD_W-1:0] i_found_slot,
    input  logic [ID_W-1:0]         i_slot_apic,
    input  logic [GEN_W-1:0]        i_slot_generation,
    input  logic                    i_slot_online,
    input  logic                    i_slot_is_boot,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        t_status                 status;
        logic [SLOT_FIELD_W-1:0] found;
        logic [ID_W-1:0]         apic;
        logic [GEN_W-1:0]        gen;
        logic                    online;
        logic                    boot;
    } t_reply;

    logic [ID_W-1:0]  tbl_apic   [CPU_SLOTS];
    logic [GEN_W-1:0] tbl_gen    [CPU_SLOTS];
    logic             tbl_online [CPU_SLOTS];
    logic             tbl_boot   [CPU_SLOTS];
    logic [GEN_W-1:0] gen_next;
    logic             inited;
    logic             poisoned;

    t_reply reply_q [$];
    int     fail_total;

    assign o_fail_count = fail_total;

    function automatic void clear_table();
        int i;
        for (i = 0; i < CPU_SLOTS; i++) begin
            tbl_apic[i]   = BAD_ID;
            tbl_gen[i]    = '0;
            tbl_online[i] = 1'b0;
            tbl_boot[i]   = 1'b0;
        end
        gen_next = GEN_FIRST;
    endfunction

    // applies one command to the slot table and returns its reply
    function automatic t_reply run_command(input logic [2:0] op,
                                           input logic [SLOT_FIELD_W-1:0] slot,
                                           input logic [ID_W-1:0] id,
                                           input logic [GEN_W-1:0] hgen);
        t_reply r;
        logic   in_range;
        int     k;
        int     hit;
        int     i;
        r.status = ST_OK;
        r.found  = NO_SLOT;
        r.apic   = BAD_ID;
        r.gen    = '0;
        r.online = 1'b0;
        r.boot   = 1'b0;
        in_range = slot < CPU_SLOTS;
        k = in_range ? int'(slot) : 0;
        hit = CPU_SLOTS;
        for (i = CPU_SLOTS - 1; i >= 0; i--) begin
            if (tbl_online[i] && tbl_apic[i] == id)
                hit = i;
        end
        if (op == OP_INIT) begin
            if (inited)
                r.status = ST_ALREADY_INIT;
            else if (!in_range)
                r.status = ST_BAD_CPU;
            else if (id == BAD_ID)
                r.status = ST_BAD_ID;
            else begin
                clear_table();
                tbl_apic[k]   = id;
                tbl_gen[k]    = gen_next;
                tbl_online[k] = 1'b1;
                tbl_boot[k]   = 1'b1;
                gen_next      = gen_next + 1'b1;
                inited        = 1'b1;
            end
        end else if (op <= OP_SNAPSHOT) begin
            if (poisoned)
                r.status = ST_POISONED;
            else if (!inited)
                r.status = ST_NOT_INIT;
            else begin
                case (op)
                    OP_ONLINE: begin
                        if (!in_range)
                            r.status = ST_BAD_CPU;
                        else if (id == BAD_ID)
                            r.status = ST_BAD_ID;
                        else if (tbl_online[k])
                            r.status = ST_ALREADY_ONLINE;
                        else if (hit < CPU_SLOTS)
                            r.status = ST_DUP_ID;
                        else if (gen_next == GEN_MAX) begin
                            poisoned = 1'b1;
                            r.status = ST_GEN_EXHAUSTED;
                        end else begin
                            tbl_apic[k]   = id;
                            tbl_gen[k]    = gen_next;
                            tbl_online[k] = 1'b1;
                            gen_next      = gen_next + 1'b1;
                        end
                    end
                    OP_OFFLINE: begin
                        if (!in_range)
                            r.status = ST_BAD_CPU;
                        else if (!tbl_online[k])
                            r.status = ST_OFFLINE;
                        else if (tbl_boot[k])
                            r.status = ST_BOOT_CPU;
                        else begin
                            tbl_apic[k]   = BAD_ID;
                            tbl_online[k] = 1'b0;
                        end
                    end
                    OP_LOOKUP: begin
                        if (id == BAD_ID)
                            r.status = ST_BAD_ID;
                        else if (hit < CPU_SLOTS)
                            r.found = SLOT_FIELD_W'(hit);
                        else
                            r.status = ST_OFFLINE;
                    end
                    OP_HANDLE: begin
                        if (!in_range)
                            r.status = ST_BAD_CPU;
                        else if (!tbl_online[k])
                            r.status = ST_OFFLINE;
                        else begin
                            r.found = slot;
                            r.gen   = tbl_gen[k];
                        end
                    end
                    OP_RESOLVE: begin
                        if (!in_range)
                            r.status = ST_BAD_CPU;
                        else if (!tbl_online[k] || hgen == '0 || tbl_gen[k] != hgen)
                            r.status = ST_STALE;
                        else
                            r.found = slot;
                    end
                    default: begin
                        if (!in_range)
                            r.status = ST_BAD_CPU;
                        else begin
                            r.apic   = tbl_apic[k];
                            r.gen    = tbl_gen[k];
                            r.online = tbl_online[k];
                            r.boot   = tbl_boot[k];
                        end
                    end
                endcase
            end
        end
        return r;
    endfunction

    function automatic int field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    initial begin
        fail_total = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            clear_table();
            inited   = 1'b0;
            poisoned = 1'b0;
            reply_q.delete();
            o_pending <= 0;
        end else begin
            if (i_strobe) begin
                if (reply_q.size() == 0) begin
                    $error("result transaction with no command waiting");
                    fail_total++;
                end else begin
                    want = reply_q.pop_front();
                    fail_total += field_bad("status", 32'(want.status), 32'(i_status));
                    fail_total += field_bad("found_slot", 32'(want.found), 32'(i_found_slot));
                    fail_total += field_bad("slot_apic", want.apic, i_slot_apic);
                    fail_total += field_bad("slot_generation", want.gen, i_slot_generation);
                    fail_total += field_bad("slot_online", 32'(want.online),
                                            32'(i_slot_online));
                    fail_total += field_bad("slot_is_boot", 32'(want.boot),
                                            32'(i_slot_is_boot));
                end
            end
            if (i_start && !i_busy)
                reply_q.push_back(run_command(i_opcode, i_slot_index, i_apic_value,
                                              i_handle_generation));
            o_pending <= reply_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_cpu_slot_registry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_slot_registry
// drives the cpu slot registry with a directed pass over every operation and
// some error paths, then with random command mixes around tracked online
// slots and random gaps; a side checker predicts and compares the replies
// ----------------------------------------------------------------------------
module tb_cpu_slot_registry;
    import csr_pkg::*;

    localparam int          CPU_SLOTS      = CPU_SLOTS_DEF;
    localparam int          RANDOM_ITEMS   = 1650;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [2:0]  OP_SPARE       = 3'd7;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [2:0]              i_opcode;
    logic [SLOT_FIELD_W-1:0] i_slot_index;
    logic [ID_W-1:0]         i_apic_value;
    logic [GEN_W-1:0]        i_handle_generation;
    logic                    o_strobe;
    logic [3:0]              o_status;
    logic [SLOT_FIELD_W-1:0] o_found_slot;
    logic [ID_W-1:0]         o_slot_apic;
    logic [GEN_W-1:0]        o_slot_generation;
    logic                    o_slot_online;
    logic                    o_slot_is_boot;
    int                      fail_count;
    int                      pending;
    int                      quiet;

    // coarse view of the slot table, only to steer the random commands
    logic             trk_on   [CPU_SLOTS];
    logic             trk_boot [CPU_SLOTS];
    logic [ID_W-1:0]  trk_id   [CPU_SLOTS];
    logic [GEN_W-1:0] trk_gen  [CPU_SLOTS];
    logic [GEN_W-1:0] trk_tag;
    logic             trk_init;
    logic [ID_W-1:0]  id_pool  [12];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cpu_slot_registry #(
        .CPU_SLOTS(CPU_SLOTS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_slot_index       (i_slot_index),
        .i_apic_value       (i_apic_value),
        .i_handle_generation(i_handle_generation),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_found_slot       (o_found_slot),
        .o_slot_apic        (o_slot_apic),
        .o_slot_generation  (o_slot_generation),
        .o_slot_online      (o_slot_online),
        .o_slot_is_boot     (o_slot_is_boot)
    );

    cpu_slot_registry_checker #(
        .CPU_SLOTS(CPU_SLOTS)
    ) reply_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_opcode           (i_opcode),
        .i_slot_index       (i_slot_index),
        .i_apic_value       (i_apic_value),
        .i_handle_generation(i_handle_generation),
        .i_strobe           (o_strobe),
        .i_status           (o_status),
        .i_found_slot       (o_found_slot),
        .i_slot_apic        (o_slot_apic),
        .i_slot_generation  (o_slot_generation),
        .i_slot_online      (o_slot_online),
        .i_slot_is_boot     (o_slot_is_boot),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("[cpu_slot_registry] ERROR");
            $finish;
        end
    end

    function automatic void track_command(input logic [2:0] op,
                                          input logic [SLOT_FIELD_W-1:0] slot,
                                          input logic [ID_W-1:0] id);
        logic dup;
        int   i;
        dup = 1'b0;
        for (i = 0; i < CPU_SLOTS; i++) begin
            if (trk_on[i] && trk_id[i] == id)
                dup = 1'b1;
        end
        if (slot < CPU_SLOTS) begin
            case (op)
                OP_INIT: begin
                    if (!trk_init && id != BAD_ID) begin
                        for (i = 0; i < CPU_SLOTS; i++) begin
                            trk_on[i]   = 1'b0;
                            trk_boot[i] = 1'b0;
                            trk_gen[i]  = '0;
                        end
                        trk_on[slot]   = 1'b1;
                        trk_boot[slot] = 1'b1;
                        trk_id[slot]   = id;
                        trk_gen[slot]  = GEN_FIRST;
                        trk_tag        = GEN_FIRST + 1'b1;
                        trk_init       = 1'b1;
                    end
                end
                OP_ONLINE: begin
                    if (trk_init && id != BAD_ID && !trk_on[slot] && !dup) begin
                        trk_on[slot]  = 1'b1;
                        trk_id[slot]  = id;
                        trk_gen[slot] = trk_tag;
                        trk_tag       = trk_tag + 1'b1;
                    end
                end
                OP_OFFLINE: begin
                    if (trk_init && trk_on[slot] && !trk_boot[slot])
                        trk_on[slot] = 1'b0;
                end
                default: ;
            endcase
        end
    endfunction

    task automatic issue(input logic [2:0] op, input logic [SLOT_FIELD_W-1:0] slot,
                         input logic [ID_W-1:0] id, input logic [GEN_W-1:0] hgen);
        start               <= 1'b1;
        i_opcode            <= op;
        i_slot_index        <= slot;
        i_apic_value        <= id;
        i_handle_generation <= hgen;
        track_command(op, slot, id);
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding reply has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic int gap_len(input int idx);
        int r;
        r = $urandom_range(0, 99);
        if (idx % 250 < 40)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SLOT_FIELD_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 88)
            return SLOT_FIELD_W'($urandom_range(0, CPU_SLOTS - 1));
        return SLOT_FIELD_W'($urandom_range(CPU_SLOTS, 255));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return id_pool[$urandom_range(0, 11)];
        if (r < 90)
            return $urandom;
        return BAD_ID;
    endfunction

    task automatic issue_random();
        logic [2:0]              op;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ID_W-1:0]         id;
        logic [GEN_W-1:0]        hgen;
        logic [GEN_W-1:0]        live;
        int                      r;
        int                      k;
        r    = $urandom_range(0, 99);
        slot = pick_slot();
        id   = $urandom;
        hgen = $urandom;
        live = (slot < CPU_SLOTS) ? trk_gen[slot] : '0;
        if (r < 26) begin
            op = OP_ONLINE;
            id = pick_id();
        end else if (r < 42) begin
            op = OP_OFFLINE;
        end else if (r < 56) begin
            op = OP_LOOKUP;
            k  = $urandom_range(0, CPU_SLOTS - 1);
            id = ($urandom_range(0, 99) < 60 && trk_on[k]) ? trk_id[k] : pick_id();
        end else if (r < 68) begin
            op = OP_HANDLE;
        end else if (r < 84) begin
            op = OP_RESOLVE;
            r  = $urandom_range(0, 99);
            if (r < 60)
                hgen = live;
            else if (r < 70)
                hgen = live + 1'b1;
            else if (r < 80)
                hgen = '0;
            else if (r < 90)
                hgen = GEN_MAX;
        end else if (r < 96) begin
            op = OP_SNAPSHOT;
        end else if (r < 98) begin
            op = OP_INIT;
            id = pick_id();
        end else begin
            op = OP_SPARE;
        end
        issue(op, slot, id, hgen);
    endtask

    initial begin
        int n;
        i_rst_n             = 1'b0;
        start               = 1'b0;
        i_opcode            = OP_INIT;
        i_slot_index        = '0;
        i_apic_value        = '0;
        i_handle_generation = '0;
        quiet               = 0;
        trk_init            = 1'b0;
        trk_tag             = GEN_FIRST;
        for (n = 0; n < CPU_SLOTS; n++) begin
            trk_on[n]   = 1'b0;
            trk_boot[n] = 1'b0;
            trk_id[n]   = BAD_ID;
            trk_gen[n]  = '0;
        end
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFE;
        id_pool[2] = 32'h8000_0000;
        id_pool[3] = 32'h0000_0001;
        id_pool[4] = 32'h7FFF_FFFF;
        id_pool[5] = 32'h5555_5555;
        id_pool[6] = 32'hAAAA_AAAA;
        for (n = 7; n < 12; n++)
            id_pool[n] = $urandom_range(2, 40);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every operation before the registry is set up
        issue(OP_ONLINE, 8'd3, 32'h10, 32'h0);
        issue(OP_OFFLINE, 8'd3, 32'h0, 32'h0);
        issue(OP_LOOKUP, 8'd0, 32'h10, 32'h0);
        issue(OP_HANDLE, 8'd3, 32'h0, 32'h0);
        issue(OP_RESOLVE, 8'd3, 32'h0, 32'h1);
        issue(OP_SNAPSHOT, 8'd3, 32'h0, 32'h0);
        issue(OP_SPARE, 8'hA5, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        // init errors, then the boot cpu, then a repeated init
        issue(OP_INIT, 8'hFF, 32'h7, 32'h0);
        issue(OP_INIT, 8'd3, BAD_ID, 32'h0);
        issue(OP_INIT, 8'd5, 32'h0, 32'h0);
        issue(OP_INIT, 8'd2, 32'h9, 32'h0);
        // bring-online success and each rejection but generation exhaustion
        issue(OP_ONLINE, 8'd15, 32'hFFFF_FFFE, 32'h0);
        issue(OP_ONLINE, 8'd16, 32'h21, 32'h0);
        issue(OP_ONLINE, 8'd0, BAD_ID, 32'h0);
        issue(OP_ONLINE, 8'd5, 32'h22, 32'h0);
        issue(OP_ONLINE, 8'd0, 32'h0, 32'h0);
        // boot cpu stays online, offline slot rejected
        issue(OP_OFFLINE, 8'd5, 32'h0, 32'h0);
        issue(OP_OFFLINE, 8'd1, 32'h0, 32'h0);
        issue(OP_LOOKUP, 8'd0, 32'hFFFF_FFFE, 32'h0);
        issue(OP_LOOKUP, 8'd0, BAD_ID, 32'h0);
        issue(OP_HANDLE, 8'd15, 32'h0, 32'h0);
        issue(OP_RESOLVE, 8'd15, 32'h0, 32'h2);
        issue(OP_RESOLVE, 8'd15, 32'h0, 32'h0);
        // offline slot keeps its generation in the snapshot
        issue(OP_OFFLINE, 8'd15, 32'h0, 32'h0);
        issue(OP_SNAPSHOT, 8'd15, 32'h0, 32'h0);
        issue(OP_SNAPSHOT, 8'd5, 32'h0, 32'h0);
        issue(OP_SNAPSHOT, 8'hFF, 32'h0, 32'h0);
        drain();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            issue_random();
            if (n % 400 == 399)
                drain();
            else
                pause(gap_len(n));
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("[cpu_slot_registry] OK");
        else
            $display("[cpu_slot_registry] ERROR");
        $finish;
    end

endmodule
